// ----- rtl/srrw_pkg.sv -----
// Shared types, constants and helper functions of the selective-repeat receive window.
// Used by the channel interfaces, the window datapath and the top level.
// No dependencies.
package srrw_pkg;

  // Field and storage widths.
  localparam int SEQ_W        = 32;
  localparam int WS_W         = 6;
  localparam int ACK_W        = 32;
  localparam int BITMAP_WIDTH = 32;
  localparam int IDX_W        = $clog2(BITMAP_WIDTH);

  typedef logic [SEQ_W-1:0]        seq_t;
  typedef logic [WS_W-1:0]         wsize_t;
  typedef logic [ACK_W-1:0]        ack_bits_t;
  typedef logic [BITMAP_WIDTH-1:0] bmap_t;
  typedef logic [IDX_W-1:0]        bidx_t;

  // Window size after reset.
  localparam wsize_t WS_RESET = WS_W'(8);

  // Operations of the shared adder/shifter in the datapath.
  typedef logic [2:0] dp_op_t;
  localparam dp_op_t OP_NONE   = 3'd0;
  localparam dp_op_t OP_LIMIT  = 3'd1;
  localparam dp_op_t OP_OFFSET = 3'd2;
  localparam dp_op_t OP_SETBIT = 3'd3;
  localparam dp_op_t OP_SLIDE  = 3'd4;

  // Status returned by the datapath to the sequencer.
  typedef struct packed {
    logic in_win;   // segment lies inside the window
    logic is_base;  // segment equals the window base
    logic bit_ok;   // bit index of the segment fits in the bitmap
    logic bit0;     // lowest bitmap bit, drives the slide loop
    logic empty;    // bitmap holds no set bit
  } dp_stat_t;

  // Low ACK_W bits of the bitmap, zero-extended when the bitmap is narrower.
  function automatic ack_bits_t ack_bits(bmap_t b);
    ack_bits_t r;
    r = '0;
    for (int i = 0; i < BITMAP_WIDTH && i < ACK_W; i++) begin
      r[i] = b[i];
    end
    return r;
  endfunction

endpackage

// ----- rtl/srrw_if.sv -----
// Valid/ready channel interfaces for segments in and acknowledgements out.
// Depends on srrw_pkg for the payload types.
interface srrw_in_if;
  logic             valid;
  logic             ready;
  srrw_pkg::seq_t   segment_seq;
  logic             is_short;

  modport source (output valid, output segment_seq, output is_short, input ready);
  modport sink   (input valid, input segment_seq, input is_short, output ready);
endinterface

interface srrw_out_if;
  logic                valid;
  logic                ready;
  srrw_pkg::seq_t      ack_base;
  srrw_pkg::ack_bits_t ack_bitmap;
  logic                accepted;
  logic                finished;

  modport source (output valid, output ack_base, output ack_bitmap, output accepted,
                  output finished, input ready);
  modport sink   (input valid, input ack_base, input ack_bitmap, input accepted,
                  input finished, output ready);
endinterface

// ----- rtl/srrw_window_dp.sv -----
// Window datapath: base and bitmap registers around one shared 33-bit adder.
// The adder forms the window limit, the segment offset and each base increment.
// Depends on srrw_pkg.
module srrw_window_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  srrw_pkg::dp_op_t  op,
  input  srrw_pkg::seq_t    seq,
  input  srrw_pkg::wsize_t  wsize,
  output srrw_pkg::seq_t    base,
  output srrw_pkg::bmap_t   bitmap,
  output srrw_pkg::dp_stat_t stat
);
  import srrw_pkg::*;

  seq_t        base_r, base_nxt;
  bmap_t       bitmap_r, bitmap_nxt;
  seq_t        offset_r;
  logic        no_borrow_r;
  logic        lim_carry_r;

  seq_t        add_a, add_b;
  logic        add_cin;
  logic [SEQ_W:0] add_sum;
  bidx_t       bit_idx;

  // Operand selection for the shared adder.
  always_comb begin
    unique case (op)
      OP_LIMIT: begin
        add_a   = base_r;
        add_b   = SEQ_W'(wsize);
        add_cin = 1'b0;
      end
      OP_OFFSET: begin
        add_a   = seq;
        add_b   = ~base_r;
        add_cin = 1'b1;
      end
      OP_SLIDE: begin
        add_a   = base_r;
        add_b   = '0;
        add_cin = 1'b1;
      end
      default: begin
        add_a   = base_r;
        add_b   = '0;
        add_cin = 1'b0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{SEQ_W{1'b0}}, add_cin};

  // Offset is 1..BITMAP_WIDTH when the bit is set, so the low bits minus one give the index.
  assign bit_idx = offset_r[IDX_W-1:0] - IDX_W'(1);

  // Next base and bitmap.
  always_comb begin
    base_nxt   = base_r;
    bitmap_nxt = bitmap_r;
    unique case (op)
      OP_SETBIT: bitmap_nxt = bitmap_r | (bmap_t'(1) << bit_idx);
      OP_SLIDE: begin
        base_nxt   = add_sum[SEQ_W-1:0];
        bitmap_nxt = bitmap_r >> 1;
      end
      default: ;
    endcase
  end

  // Window state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      bitmap_r <= '0;
    end else begin
      base_r   <= base_nxt;
      bitmap_r <= bitmap_nxt;
    end
  end

  // Intermediate results of the window check.
  always_ff @(posedge clk) begin
    if (op == OP_LIMIT) begin
      lim_carry_r <= add_sum[SEQ_W];
    end
    if (op == OP_OFFSET) begin
      offset_r    <= add_sum[SEQ_W-1:0];
      no_borrow_r <= add_sum[SEQ_W];
    end
  end

  // Inside the window when seq >= base, the limit did not wrap and the offset is below the size.
  assign stat.in_win  = no_borrow_r && !lim_carry_r && (offset_r[SEQ_W-1:WS_W] == '0) &&
                        (offset_r[WS_W-1:0] < wsize);
  assign stat.is_base = (offset_r == '0);
  assign stat.bit_ok  = (offset_r != '0) && (offset_r <= SEQ_W'(BITMAP_WIDTH));
  assign stat.bit0    = bitmap_r[0];
  assign stat.empty   = (bitmap_r == '0);

  assign base   = base_r;
  assign bitmap = bitmap_r;

endmodule

// ----- rtl/selective_repeat_receive_window_core.sv -----
// Top level of the selective-repeat receive window: sequencer, window size register and
// acknowledgement output register. Depends on srrw_pkg, srrw_if.sv and srrw_window_dp.
//
//   channel   direction  handshake           payload
//   in_ch     in         valid/ready         segment_seq[31:0], is_short
//   out_ch    out        valid/ready         ack_base[31:0], ack_bitmap[31:0], accepted, finished
//   cfg_*     in         cfg_wr_en           cfg_wr_data[5:0] (window size)
//
// A segment passes through the limit, offset and decision steps to the final step; one that hits
// the base first slides past it and past the run of set bitmap bits behind it: the shared adder
// advances the base and the bitmap shifts by one bit per cycle.
// in_ch.ready is high only while the sequencer is idle; a waiting acknowledgement does not
// block the next segment, which stalls at its final step until out_ch is free.
// Synchronous active-low reset clears the base, the bitmap and the window size to 8.
module selective_repeat_receive_window_core (
  input  logic                  clk,
  input  logic                  rst_n,
  srrw_in_if.sink               in_ch,
  srrw_out_if.source            out_ch,
  input  logic                  cfg_wr_en,
  input  srrw_pkg::wsize_t      cfg_wr_data
);
  import srrw_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LIM   = 3'd1;
  localparam logic [2:0] ST_OFS   = 3'd2;
  localparam logic [2:0] ST_DEC   = 3'd3;
  localparam logic [2:0] ST_SLIDE = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state_r, state_nxt;
  wsize_t     wsize_r;
  seq_t       seq_r;
  logic       short_r;
  logic       acc_r, acc_nxt;

  logic       out_valid_r, out_valid_nxt;
  seq_t       out_base_r;
  ack_bits_t  out_bitmap_r;
  logic       out_acc_r;
  logic       out_fin_r;

  dp_op_t     op;
  seq_t       base;
  bmap_t      bitmap;
  dp_stat_t   stat;
  logic       in_fire;
  logic       out_load;

  srrw_window_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (op),
    .seq    (seq_r),
    .wsize  (wsize_r),
    .base   (base),
    .bitmap (bitmap),
    .stat   (stat)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  // Sequencer: operation for the datapath and next state.
  always_comb begin
    op        = OP_NONE;
    state_nxt = state_r;
    acc_nxt   = acc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LIM;
          acc_nxt   = 1'b0;
        end
      end
      ST_LIM: begin
        op        = OP_LIMIT;
        state_nxt = ST_OFS;
      end
      ST_OFS: begin
        op        = OP_OFFSET;
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        priority if (stat.in_win && stat.is_base) begin
          acc_nxt   = 1'b1;
          state_nxt = ST_SLIDE;
        end else if (stat.in_win && stat.bit_ok) begin
          op        = OP_SETBIT;
          acc_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_SLIDE: begin
        // The step that shifts out a clear bit is the last one.
        op = OP_SLIDE;
        if (!stat.bit0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wsize_r <= WS_RESET;
      acc_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      if (cfg_wr_en) begin
        wsize_r <= cfg_wr_data;
      end
    end
  end

  // Segment capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      seq_r   <= in_ch.segment_seq;
      short_r <= in_ch.is_short;
    end
  end

  // Acknowledgement output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_base_r   <= base;
      out_bitmap_r <= ack_bits(bitmap);
      out_acc_r    <= acc_r;
      out_fin_r    <= acc_r && short_r && stat.empty;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ack_base   = out_base_r;
  assign out_ch.ack_bitmap = out_bitmap_r;
  assign out_ch.accepted   = out_acc_r;
  assign out_ch.finished   = out_fin_r;

  // Each slide step advances the base by exactly one.
  a_slide_inc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SLIDE |=> base == $past(base) + SEQ_W'(1))
    else $error("slide step did not advance the base by one");

  // A segment outside the window leaves the window state untouched.
  a_reject_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEC) && !stat.in_win |=> $stable(base) && $stable(bitmap))
    else $error("rejected segment changed the window state");

  // A finished acknowledgement always reports an accepted segment.
  a_fin_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fin_r |-> out_acc_r)
    else $error("finished flag without accepted flag");

  // A new acknowledgement is only loaded from the final sequencer step.
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("acknowledgement loaded outside the final step");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for selective_repeat_receive_window_core.
// Depends on srrw_pkg and the channel interfaces in srrw_if.sv; predicts each
// acknowledgement from its own copy of the window state and checks it field by field.
module testbench;
  import srrw_pkg::*;

  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 48;
  localparam int unsigned PHASE_ITEMS   = 85;
  localparam int unsigned NUM_PHASES    = 10;
  localparam int unsigned CALM_PHASES   = 2;

  // Window sizes for the random phases, extremes included.
  localparam wsize_t WS_PLAN [NUM_PHASES] = '{
    6'd1, 6'd32, 6'd63, 6'd0, 6'd5, 6'd33, 6'd17, 6'd2, 6'd48, 6'd8
  };

  typedef struct packed {
    seq_t      base;
    ack_bits_t bitmap;
    logic      accepted;
    logic      finished;
  } ack_t;

  // Tracks the receive window and holds the acknowledgements still owed.
  class ack_tracker;
    seq_t        win_base;
    bmap_t       rx_bitmap;
    wsize_t      win_size;
    ack_t        acks_due [$];
    int unsigned errors;

    function new();
      win_base  = '0;
      rx_bitmap = '0;
      win_size  = WS_RESET;
      errors    = 0;
    endfunction

    function void set_window(wsize_t ws);
      win_size = ws;
    endfunction

    function int unsigned pending();
      return acks_due.size();
    endfunction

    // Update the window for one accepted segment transaction and queue its ack.
    function void note_segment(seq_t seq, logic short_seg);
      seq_t limit;
      seq_t offset;
      logic hit;
      ack_t a;
      limit = win_base + seq_t'(win_size);
      hit   = 1'b0;
      if (seq < limit && seq >= win_base) begin
        if (seq == win_base) begin
          // Slide past the base and every consecutive received segment.
          hit = 1'b1;
          while (rx_bitmap[0]) begin
            win_base  = win_base + 1;
            rx_bitmap = rx_bitmap >> 1;
          end
          win_base  = win_base + 1;
          rx_bitmap = rx_bitmap >> 1;
        end else begin
          offset = seq - win_base - 1;
          if (offset < BITMAP_WIDTH) begin
            hit = 1'b1;
            rx_bitmap[offset[IDX_W-1:0]] = 1'b1;
          end
        end
      end
      a.base     = win_base;
      a.bitmap   = ack_bits_t'(rx_bitmap);
      a.accepted = hit;
      a.finished = hit && short_seg && (rx_bitmap == '0);
      acks_due.push_back(a);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      if (errors < 40) begin
        $display("mismatch %s: got %h, want %h", what, got, want);
      end
      errors++;
    endtask

    // Compare one acknowledgement transaction with the oldest expectation.
    task check_ack(ack_t got);
      ack_t want;
      if (acks_due.size() == 0) begin
        report("ack with no segment", got.base, '0);
        return;
      end
      want = acks_due.pop_front();
      if (got.base != want.base) report("ack_base", got.base, want.base);
      if (got.bitmap != want.bitmap) report("ack_bitmap", got.bitmap, want.bitmap);
      if (got.accepted != want.accepted) begin
        report("accepted", 32'(got.accepted), 32'(want.accepted));
      end
      if (got.finished != want.finished) begin
        report("finished", 32'(got.finished), 32'(want.finished));
      end
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  wsize_t     cfg_wr_data;
  logic       src_idle_on;
  logic       snk_idle_on;
  logic       hold_req;
  logic       hold_done;
  int unsigned quiet_cycles;
  ack_tracker sb;

  srrw_in_if  in_ch ();
  srrw_out_if out_ch ();

  selective_repeat_receive_window_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one segment, with an optional gap first, and wait for its transaction.
  task automatic send_seg(seq_t seq, logic short_seg);
    int unsigned gap;
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.segment_seq <= seq;
    in_ch.is_short    <= short_seg;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_segment(seq, short_seg);
  endtask

  task automatic send_rel(seq_t offset, logic short_seg);
    send_seg(sb.win_base + offset, short_seg);
  endtask

  // Stop offering and wait until every acknowledgement has come back.
  task automatic drain_acks();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(wsize_t ws);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ws;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_window(ws);
  endtask

  // Pick a lone segment number: mostly in the window, some beyond it, some
  // stale, some anywhere in the sequence space.
  function automatic seq_t pick_seq();
    int unsigned r;
    int unsigned ws;
    seq_t        base;
    base = sb.win_base;
    ws   = 32'(sb.win_size);
    r    = $urandom_range(0, 99);
    if (r < 55) return base + seq_t'($urandom_range(0, (ws == 0) ? 0 : ws - 1));
    if (r < 70) return base + seq_t'($urandom_range(ws, ws + 40));
    if (r < 82) return base - seq_t'($urandom_range(1, 40));
    return seq_t'($urandom);
  endfunction

  // Random traffic: out-of-order bursts that end with the base, mixed with noise.
  task automatic run_phase(int unsigned n_items);
    int unsigned sent;
    int          k;
    int          span;
    int          i;
    int          j;
    int          tmp;
    int          offs [BITMAP_WIDTH];
    seq_t        base;
    sent = 0;
    while (sent < n_items) begin
      if (sb.win_size > 1 && $urandom_range(0, 9) < 4) begin
        span = (sb.win_size > BITMAP_WIDTH) ? BITMAP_WIDTH : sb.win_size - 1;
        k    = $urandom_range(1, span);
        base = sb.win_base;
        for (i = 0; i < k; i++) offs[i] = i + 1;
        for (i = k - 1; i > 0; i--) begin
          j       = $urandom_range(0, i);
          tmp     = offs[i];
          offs[i] = offs[j];
          offs[j] = tmp;
        end
        for (i = 0; i < k; i++) begin
          send_seg(base + seq_t'(offs[i]), $urandom_range(0, 7) == 0);
          // Occasionally repeat a segment that was already sent.
          if ($urandom_range(0, 9) == 0) begin
            send_seg(base + seq_t'(offs[$urandom_range(0, i)]), $urandom_range(0, 1) == 0);
            sent++;
          end
        end
        send_seg(base, $urandom_range(0, 2) == 0);
        sent += k + 1;
      end else begin
        send_seg(pick_seq(), $urandom_range(0, 3) == 0);
        sent++;
      end
    end
  endtask

  // Receiver: random stall bursts, and one long hold when asked.
  initial begin
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Check every acknowledgement transaction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_ack({out_ch.ack_base, out_ch.ack_bitmap, out_ch.accepted, out_ch.finished});
    end
  end

  // Watchdog: end the run when no transaction has happened for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  // Main sequence.
  initial begin
    sb                = new();
    src_idle_on       = 1'b0;
    snk_idle_on       = 1'b0;
    hold_req          = 1'b0;
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.segment_seq <= '0;
    in_ch.is_short    <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Default window: short first segment, far and stale numbers, window edge,
    // duplicates, and a slide over a run of received segments.
    send_seg(32'd0, 1'b1);
    send_seg(32'hFFFF_FFFF, 1'b1);
    send_seg(32'd0, 1'b0);
    send_rel(32'd7, 1'b0);
    send_rel(32'd8, 1'b0);
    send_rel(32'd7, 1'b0);
    send_rel(32'd2, 1'b1);
    send_rel(32'd1, 1'b0);
    send_rel(32'd0, 1'b1);
    send_rel(32'd4, 1'b1);
    send_rel(32'd0, 1'b1);
    send_seg(32'h8000_0000, 1'b0);
    send_seg(32'h5555_5555, 1'b1);
    send_seg(32'hAAAA_AAAA, 1'b0);

    // Zero window accepts nothing.
    drain_acks();
    write_window(6'd0);
    send_rel(32'd0, 1'b1);
    send_rel(32'd1, 1'b0);

    // Window wider than the bitmap: the top bit fits, one past it does not.
    drain_acks();
    write_window(6'd63);
    send_rel(32'd33, 1'b0);
    send_rel(32'd32, 1'b1);
    send_rel(32'd1, 1'b0);
    send_rel(32'd0, 1'b1);
    send_rel(32'd30, 1'b1);
    send_rel(32'd62, 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_acks();
      write_window(WS_PLAN[p]);
      src_idle_on = (p < NUM_PHASES - CALM_PHASES) && ($urandom_range(0, 3) != 0);
      snk_idle_on = (p < NUM_PHASES - CALM_PHASES) && ($urandom_range(0, 3) != 0);
      if (p == 1) begin
        src_idle_on = 1'b0;
        hold_req    = 1'b1;
      end
      run_phase(PHASE_ITEMS);
    end

    drain_acks();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
